>>> src/rlc_pkg.sv
// Shared types and constants for the rainbow LED color generator.
// Holds the request/response word types, CSR indexes and field widths.
// No dependencies.
package rlc_pkg;

   // Field widths
   localparam int STRIP_W    = 11;
   localparam int STEP_W     = 10;
   localparam int WAVE_W     = 16;
   localparam int INDEX_W    = 10;
   localparam int COLOR_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // wave_count is Q8.8
   localparam int WAVE_FRAC_W = 8;

   // Angles in whole degrees
   localparam int DEG_FULL   = 360;
   localparam int DEG_SECTOR = 60;
   localparam int PHASE_W    = 9;
   localparam int SECTOR_W   = 3;

   // led_index * 360 and that times wave_count
   localparam int SCALED_W = INDEX_W + PHASE_W;
   localparam int PROD_W   = SCALED_W + WAVE_W;

   // Parameter defaults
   localparam int MAX_LEDS_DEF      = 1024;
   localparam int HUE_FRAC_BITS_DEF = 8;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_COUNT   = 2'd2;

   typedef struct packed {
      logic               frame_start;
      logic [INDEX_W-1:0] led_index;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rsp_word_type;

   // Largest usable strip length: MAX_LEDS, capped by the CSR field range
   function automatic int len_cap(input int max_leds);
      int cap;
      cap = (1 << STRIP_W) - 1;
      if (max_leds < cap) begin
         cap = max_leds;
      end
      return cap;
   endfunction

endpackage

>>> src/rlc_div.sv
// Shared bit-serial restoring divider, one quotient bit per cycle.
// Quotient is kept reduced modulo MODULUS as it is built.
// Depends on nothing.
module rlc_div #(
   parameter int DEN_W   = 25,
   parameter int SHIFT_W = 35,
   parameter int QUO_W   = 17,
   parameter int CNT_W   = 6,
   parameter int MODULUS = 92160
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DEN_W-1:0]   rem_init,
   input  logic [SHIFT_W-1:0] num_init,
   input  logic [DEN_W-1:0]   den,
   input  logic [CNT_W-1:0]   steps,
   output logic               done,
   output logic [QUO_W-1:0]   quo,
   output logic [DEN_W-1:0]   rem
);

   logic               run_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   rem_in;
   logic [DEN_W-1:0]   den_ff;
   logic [SHIFT_W-1:0] num_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic [QUO_W-1:0]   quo_in;
   logic [DEN_W:0]     trial;
   logic [DEN_W:0]     diff;
   logic               take;
   logic [QUO_W:0]     qtrial;
   logic               last_step;

   localparam logic [QUO_W:0] MOD_V = (QUO_W+1)'(MODULUS);

   always_comb begin
      trial     = {rem_ff, num_ff[SHIFT_W-1]};
      diff      = trial - {1'b0, den_ff};
      take      = trial >= {1'b0, den_ff};
      rem_in    = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      // quotient grows by one bit; one subtract keeps it below MODULUS
      qtrial    = {quo_ff, take};
      quo_in    = (qtrial >= MOD_V) ? QUO_W'(qtrial - MOD_V) : qtrial[QUO_W-1:0];
      last_step = cnt_ff == CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && last_step;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && last_step) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         num_ff <= num_init;
         den_ff <= den;
         cnt_ff <= steps;
         quo_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         num_ff <= num_ff << 1;
         cnt_ff <= cnt_ff - CNT_W'(1);
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

>>> src/rlc_seq.sv
// Sequencer: frame phase, operand setup for the three divider passes,
// sector-to-RGB mapping and the response output register.
// Depends on rlc_pkg and rlc_div.
module rlc_seq import rlc_pkg::*; #(
   parameter int MAX_LEDS      = MAX_LEDS_DEF,
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
   parameter int LEN_W         = $clog2(len_cap(MAX_LEDS) + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_word_type             req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_word_type             rsp_word,
   input  logic [LEN_W-1:0]         strip_len,
   input  logic signed [STEP_W-1:0] phase_step,
   input  logic [WAVE_W-1:0]        wave_count
);

   localparam int FULL    = DEG_FULL << HUE_FRAC_BITS;
   localparam int SPAN    = DEG_SECTOR << HUE_FRAC_BITS;
   localparam int HUE_W   = $clog2(FULL);
   localparam int SPAN_W  = $clog2(SPAN);
   localparam int RAMP_W  = SPAN_W + COLOR_W;
   localparam int NUM_W   = PROD_W + HUE_FRAC_BITS;
   localparam int SHIFT_W = NUM_W - WAVE_FRAC_W;
   localparam int DEN_A   = LEN_W + WAVE_FRAC_W;
   localparam int DEN_B   = $clog2(SPAN + 1);
   localparam int DEN_W   = (DEN_A > DEN_B) ? DEN_A : DEN_B;
   localparam int CNT_W   = $clog2(SHIFT_W + 1);
   localparam int PSUM_W  = PHASE_W + 3;

   localparam logic [HUE_W:0]  FULL_V = (HUE_W+1)'(FULL);
   localparam logic signed [PSUM_W-1:0] DEG_FULL_S = PSUM_W'(DEG_FULL);

   // Hue sectors of 60 degrees
   localparam logic [SECTOR_W-1:0] SEC_RED_YELLOW    = 3'd0;
   localparam logic [SECTOR_W-1:0] SEC_YELLOW_GREEN  = 3'd1;
   localparam logic [SECTOR_W-1:0] SEC_GREEN_CYAN    = 3'd2;
   localparam logic [SECTOR_W-1:0] SEC_CYAN_BLUE     = 3'd3;
   localparam logic [SECTOR_W-1:0] SEC_BLUE_MAGENTA  = 3'd4;
   localparam logic [COLOR_W-1:0]  COLOR_FULL        = '1;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_D1, S_W1, S_D2, S_W2, S_D3, S_W3, S_OUT
   } state_type;

   function automatic logic signed [PSUM_W-1:0] wrap_once(
      input logic signed [PSUM_W-1:0] p
   );
      logic signed [PSUM_W-1:0] r;
      r = p;
      if (p < 0) begin
         r = p + DEG_FULL_S;
      end else if (p >= DEG_FULL_S) begin
         r = p - DEG_FULL_S;
      end
      return r;
   endfunction

   function automatic rsp_word_type sector_color(
      input logic [SECTOR_W-1:0] sector,
      input logic [COLOR_W-1:0]  up,
      input logic [COLOR_W-1:0]  down
   );
      rsp_word_type c;
      unique case (sector)
         SEC_RED_YELLOW:   c = '{red: COLOR_FULL, green: up,         blue: '0};
         SEC_YELLOW_GREEN: c = '{red: down,       green: COLOR_FULL, blue: '0};
         SEC_GREEN_CYAN:   c = '{red: '0,         green: COLOR_FULL, blue: up};
         SEC_CYAN_BLUE:    c = '{red: '0,         green: down,       blue: COLOR_FULL};
         SEC_BLUE_MAGENTA: c = '{red: up,         green: '0,         blue: COLOR_FULL};
         default:          c = '{red: COLOR_FULL, green: '0,         blue: down};
      endcase
      return c;
   endfunction

   state_type             state_ff;
   logic [PHASE_W-1:0]    phase_ff;
   logic [PHASE_W-1:0]    phase_in;
   logic [SCALED_W-1:0]   scaled_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [HUE_W-1:0]      hue_ff;
   logic [HUE_W-1:0]      hue_in;
   logic [SECTOR_W-1:0]   sector_ff;
   logic [SPAN_W-1:0]     off_ff;
   rsp_word_type          color_ff;
   rsp_word_type          color_in;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   logic [HUE_W:0]        hue_sum;
   logic signed [PSUM_W-1:0] psum;
   logic [NUM_W-1:0]      num1;
   logic [RAMP_W-1:0]     ramp;
   logic [COLOR_W-1:0]    up;
   logic [COLOR_W-1:0]    down;
   logic                  accept;
   logic                  out_free;

   logic                  div_start;
   logic [DEN_W-1:0]      div_rem_init;
   logic [SHIFT_W-1:0]    div_num_init;
   logic [DEN_W-1:0]      div_den;
   logic [CNT_W-1:0]      div_steps;
   logic                  div_done;
   logic [HUE_W-1:0]      div_quo;
   logic [DEN_W-1:0]      div_rem;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // phase + step spans -512..870; two wrap steps land in 0..359
      psum     = $signed({3'b000, phase_ff}) + PSUM_W'(phase_step);
      phase_in = PHASE_W'(wrap_once(wrap_once(psum)));

      hue_sum  = (HUE_W+1)'(div_quo) + ((HUE_W+1)'(phase_ff) << HUE_FRAC_BITS);
      hue_in   = (hue_sum >= FULL_V) ? HUE_W'(hue_sum - FULL_V) : hue_sum[HUE_W-1:0];

      num1     = NUM_W'(prod_ff) << HUE_FRAC_BITS;
      ramp     = {off_ff, {COLOR_W{1'b0}}} - RAMP_W'(off_ff);

      // down = 255 - ceil(255*off/span)
      up       = div_quo[COLOR_W-1:0];
      down     = ~up - COLOR_W'(|div_rem);
      color_in = sector_color(sector_ff, up, down);
   end

   // Divider operands per pass; the preload holds the bits known to give
   // a zero quotient, so each pass only runs the bits that matter.
   always_comb begin
      div_start    = 1'b0;
      div_rem_init = DEN_W'(num1[NUM_W-1 -: WAVE_FRAC_W]);
      div_num_init = num1[SHIFT_W-1:0];
      div_den      = DEN_W'(strip_len) << WAVE_FRAC_W;
      div_steps    = CNT_W'(SHIFT_W);
      unique case (state_ff)
         S_D1: begin
            div_start = 1'b1;
         end
         S_D2: begin
            div_start    = 1'b1;
            div_rem_init = DEN_W'(hue_ff[HUE_W-1:SECTOR_W]);
            div_num_init = {hue_ff[SECTOR_W-1:0], {(SHIFT_W-SECTOR_W){1'b0}}};
            div_den      = DEN_W'(SPAN);
            div_steps    = CNT_W'(SECTOR_W);
         end
         S_D3: begin
            div_start    = 1'b1;
            div_rem_init = DEN_W'(ramp[RAMP_W-1:COLOR_W]);
            div_num_init = {ramp[COLOR_W-1:0], {(SHIFT_W-COLOR_W){1'b0}}};
            div_den      = DEN_W'(SPAN);
            div_steps    = CNT_W'(COLOR_W);
         end
         default: begin
         end
      endcase
   end

   rlc_div #(
      .DEN_W   (DEN_W),
      .SHIFT_W (SHIFT_W),
      .QUO_W   (HUE_W),
      .CNT_W   (CNT_W),
      .MODULUS (FULL)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .num_init (div_num_init),
      .den      (div_den),
      .steps    (div_steps),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new color loads as the old one leaves
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  scaled_ff <= SCALED_W'(req_word.led_index) * SCALED_W'(DEG_FULL);
                  if (req_word.frame_start) begin
                     phase_ff <= phase_in;
                  end
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(scaled_ff) * PROD_W'(wave_count);
               state_ff <= S_D1;
            end
            S_D1: state_ff <= S_W1;
            S_W1: begin
               if (div_done) begin
                  hue_ff   <= hue_in;
                  state_ff <= S_D2;
               end
            end
            S_D2: state_ff <= S_W2;
            S_W2: begin
               if (div_done) begin
                  sector_ff <= div_quo[SECTOR_W-1:0];
                  off_ff    <= div_rem[SPAN_W-1:0];
                  state_ff  <= S_D3;
               end
            end
            S_D3: state_ff <= S_W3;
            S_W3: begin
               if (div_done) begin
                  color_ff <= color_in;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_word_ff  <= color_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> src/rainbow_led_color_generator_top.sv
// Rainbow LED color generator, top level. Depends on rlc_pkg and rlc_seq.
// Each word takes three passes through the shared bit-serial divider:
// 27 + HUE_FRAC_BITS steps for the hue quotient, 3 for the sector and
// 8 for the ramp, between the sequencer's setup and output states.
// One word in flight; the next request waits until the sequencer is idle.
// Reset (sync, active high): strip_length 1, phase_step 0, wave_count 0, phase 0.
module rainbow_led_color_generator_top import rlc_pkg::*; #(
   parameter int MAX_LEDS      = MAX_LEDS_DEF,
   parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   // CSR write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Strip length after clamping to 1..cap
   localparam int LEN_CAP = len_cap(MAX_LEDS);
   localparam int LEN_W   = $clog2(LEN_CAP + 1);
   localparam logic [STRIP_W-1:0] LEN_CAP_V = STRIP_W'(LEN_CAP);

   logic [STRIP_W-1:0]        strip_length_ff;
   logic signed [STEP_W-1:0]  phase_step_ff;
   logic [WAVE_W-1:0]         wave_count_ff;
   logic [LEN_W-1:0]          strip_len;

   // CSR writes always land. The user must issue them only while the block is idle,
   // unchecked by the block, so the sequencer sees stable settings for a whole word.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_length_ff <= STRIP_W'(1);
         phase_step_ff   <= '0;
         wave_count_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STRIP_LENGTH: strip_length_ff <= csr_wdata[STRIP_W-1:0];
            CSR_PHASE_STEP:   phase_step_ff   <= $signed(csr_wdata[STEP_W-1:0]);
            CSR_WAVE_COUNT:   wave_count_ff   <= csr_wdata[WAVE_W-1:0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // Zero length acts as one LED; anything past the cap saturates.
   always_comb begin
      priority if (strip_length_ff == '0) begin
         strip_len = LEN_W'(1);
      end else if (strip_length_ff > LEN_CAP_V) begin
         strip_len = LEN_W'(LEN_CAP);
      end else begin
         strip_len = LEN_W'(strip_length_ff);
      end
   end

   // Sequencer owns the frame phase, the divider and the output register.
   // req_stall drops only in its idle state; the finished color sits in the
   // output register, so a new word is taken while rsp is still stalled.
   rlc_seq #(
      .MAX_LEDS      (MAX_LEDS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .LEN_W         (LEN_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .strip_len  (strip_len),
      .phase_step (phase_step_ff),
      .wave_count (wave_count_ff)
   );

endmodule

>>> src/rlc_chk.sv
// Port-level checker for the rainbow LED color generator, bound to the top.
// Depends on rlc_pkg.
module rlc_chk import rlc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_word_type          rsp_word
);

   // one word in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a word is in flight");

   // a result cannot appear right after a new word was taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early after accept");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result changed");

endmodule

bind rainbow_led_color_generator_top rlc_chk u_chk (.*);

>>> sim/rainbow_led_color_generator_top_tb.sv
// Self-checking testbench for rainbow_led_color_generator_top.
// Directed and random LED words against an in-bench color predictor.
// Depends on rlc_pkg and the generator RTL.
module rainbow_led_color_generator_top_tb;
   import rlc_pkg::*;

   // Wait bound covering the generator's accept-to-result time, plus slack for draining
   localparam int LATENCY_CYCLES = HUE_FRAC_BITS_DEF + 46;
   localparam int SETTLE_CYCLES  = LATENCY_CYCLES + 16;

   // Hue fixed point: whole degrees scaled by 2^HUE_FRAC_BITS
   localparam longint unsigned HUE_ONE    = 64'd1 << HUE_FRAC_BITS_DEF;
   localparam longint unsigned HUE_TURN   = DEG_FULL * HUE_ONE;
   localparam longint unsigned HUE_SECTOR = DEG_SECTOR * HUE_ONE;
   localparam longint unsigned WAVE_ONE   = 64'd1 << WAVE_FRAC_W;
   localparam int              COLOR_FULL = (1 << COLOR_W) - 1;

   // Index with no register behind it; writes there must leave state alone
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // Channel pattern of each 60-degree hue sector
   typedef enum int unsigned {
      SECTOR_RED_GREEN_UP,
      SECTOR_GREEN_RED_DOWN,
      SECTOR_GREEN_BLUE_UP,
      SECTOR_BLUE_GREEN_DOWN,
      SECTOR_BLUE_RED_UP,
      SECTOR_RED_BLUE_DOWN
   } hue_sector_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the block's registers and frame phase, as after reset
   logic [STRIP_W-1:0]        cfg_strip       = 11'd1;
   logic signed [STEP_W-1:0]  cfg_step        = '0;
   logic [WAVE_W-1:0]         cfg_wave        = '0;
   int                        frame_phase_deg = 0;

   // Colors predicted for accepted words, oldest first
   rsp_word_type pending_colors[$];
   int           error_count  = 0;

   // Idle percentages for the two sides, per cycle
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   rainbow_led_color_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Color of one LED. Advances the frame phase first when the word opens a frame.
   function automatic rsp_word_type predict_color(input req_word_type w);
      int              step_deg;
      int              phase_next;
      longint unsigned len;
      longint unsigned idx;
      longint unsigned hue;
      longint unsigned off;
      longint unsigned up;
      longint unsigned down;
      hue_sector_type  sector;
      rsp_word_type    rgb;
      if (w.frame_start) begin
         step_deg   = cfg_step;
         phase_next = (frame_phase_deg + step_deg) % DEG_FULL;
         // negative step: C-style remainder, fold back into 0..359
         if (phase_next < 0) begin
            phase_next += DEG_FULL;
         end
         frame_phase_deg = phase_next;
      end
      // zero length acts as one, anything past MAX_LEDS saturates
      len = cfg_strip;
      if (len == 0) begin
         len = 1;
      end
      if (len > MAX_LEDS_DEF) begin
         len = MAX_LEDS_DEF;
      end
      // sweep hue, truncated to the hue's fraction bits; indexes past the strip keep going
      idx = w.led_index;
      hue = (DEG_FULL * idx * cfg_wave * HUE_ONE) / (WAVE_ONE * len);
      hue = (hue % HUE_TURN + frame_phase_deg * HUE_ONE) % HUE_TURN;
      sector = hue_sector_type'(hue / HUE_SECTOR);
      off    = hue % HUE_SECTOR;
      up     = (COLOR_FULL * off) / HUE_SECTOR;
      down   = (COLOR_FULL * (HUE_SECTOR - off)) / HUE_SECTOR;
      case (sector)
         SECTOR_RED_GREEN_UP: begin
            rgb = '{COLOR_W'(COLOR_FULL), COLOR_W'(up), '0};
         end
         SECTOR_GREEN_RED_DOWN: begin
            rgb = '{COLOR_W'(down), COLOR_W'(COLOR_FULL), '0};
         end
         SECTOR_GREEN_BLUE_UP: begin
            rgb = '{'0, COLOR_W'(COLOR_FULL), COLOR_W'(up)};
         end
         SECTOR_BLUE_GREEN_DOWN: begin
            rgb = '{'0, COLOR_W'(down), COLOR_W'(COLOR_FULL)};
         end
         SECTOR_BLUE_RED_UP: begin
            rgb = '{COLOR_W'(up), '0, COLOR_W'(COLOR_FULL)};
         end
         default: begin
            rgb = '{COLOR_W'(COLOR_FULL), '0, COLOR_W'(down)};
         end
      endcase
      return rgb;
   endfunction

   task automatic report_error(input string what, input rsp_word_type want,
                               input rsp_word_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR %s at %0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                  what, $time, want.red, want.green, want.blue,
                  got.red, got.green, got.blue);
      end
   endtask

   // Result side: check every accepted word, then pick the next stall
   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            report_error("result with no word pending", '0, rsp_word);
         end else begin
            want = pending_colors.pop_front();
            if (rsp_word.red !== want.red || rsp_word.green !== want.green ||
                rsp_word.blue !== want.blue) begin
               report_error("color mismatch", want, rsp_word);
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // Send one LED word; the prediction is taken at the accepting edge.
   // Valid stays high afterwards so back-to-back words keep it asserted between them.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      pending_colors.push_back(predict_color(w));
   endtask

   // Drop valid, let every pending color come back, then let the pipe empty
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; valid is left high for the caller to lower
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STRIP_LENGTH: cfg_strip = data[STRIP_W-1:0];
         CSR_PHASE_STEP:   cfg_step  = data[STEP_W-1:0];
         CSR_WAVE_COUNT:   cfg_wave  = data[WAVE_W-1:0];
         default: ;
      endcase
   endtask

   // Full register set, written back to back; only call with the block idle
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] strip_data,
                                 input logic [CSR_DATA_W-1:0] step_data,
                                 input logic [CSR_DATA_W-1:0] wave_data,
                                 input bit poke_unmapped);
      if (poke_unmapped) begin
         csr_put(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      end
      csr_put(CSR_STRIP_LENGTH, strip_data);
      csr_put(CSR_PHASE_STEP, step_data);
      csr_put(CSR_WAVE_COUNT, wave_data);
      csr_valid <= 1'b0;
   endtask

   // Reset values: no sweep, zero phase, so every LED is pure red
   task automatic test_reset_state();
      send_word(req_word_type'{1'b0, 10'd0});
      send_word(req_word_type'{1'b1, 10'd1023});
      send_word(req_word_type'{1'b0, 10'd512});
      settle_idle();
   endtask

   // Largest wave count and full-turn phase steps in both directions
   task automatic test_sweep_extremes();
      apply_settings(CSR_DATA_W'(MAX_LEDS_DEF), CSR_DATA_W'(360), 16'hFFFF, 1'b1);
      send_word(req_word_type'{1'b1, 10'd0});
      send_word(req_word_type'{1'b0, 10'd1});
      send_word(req_word_type'{1'b0, 10'd1023});
      send_word(req_word_type'{1'b1, 10'd1023});
      settle_idle();
      // zero strip length behaves as one LED
      apply_settings(16'h0000, CSR_DATA_W'(-360), 16'h0100, 1'b0);
      send_word(req_word_type'{1'b1, 10'd0});
      send_word(req_word_type'{1'b0, 10'd1023});
      send_word(req_word_type'{1'b1, 10'd512});
      settle_idle();
   endtask

   // Over-long strip saturates; all-ones data also gives a step of -1 degree
   task automatic test_strip_limits();
      apply_settings(16'hFFFF, 16'hFFFF, 16'h0080, 1'b1);
      send_word(req_word_type'{1'b1, 10'd1023});
      send_word(req_word_type'{1'b1, 10'd0});
      send_word(req_word_type'{1'b1, 10'd700});
      settle_idle();
      apply_settings(CSR_DATA_W'(MAX_LEDS_DEF + 1), CSR_DATA_W'(1), 16'h0001, 1'b0);
      send_word(req_word_type'{1'b0, 10'd1023});
      settle_idle();
   endtask

   // Short strip, LEDs far past its end, and a step one degree short of a sector
   task automatic test_phase_wrap();
      apply_settings(CSR_DATA_W'(10), CSR_DATA_W'(59), 16'h0300, 1'b0);
      send_word(req_word_type'{1'b1, 10'd9});
      send_word(req_word_type'{1'b0, 10'd10});
      send_word(req_word_type'{1'b1, 10'd500});
      send_word(req_word_type'{1'b1, 10'd1023});
      settle_idle();
   endtask

   // Random settings, each followed mostly by well-formed frames and some noise
   task automatic run_random_frames(input int count);
      int                    sent;
      int                    span;
      int                    base;
      logic [CSR_DATA_W-1:0] strip_d;
      logic [CSR_DATA_W-1:0] step_d;
      logic [CSR_DATA_W-1:0] wave_d;
      req_word_type          w;
      sent = 0;
      while (sent < count) begin
         settle_idle();
         // upper data bits are random so every wdata bit toggles
         strip_d = CSR_DATA_W'($urandom);
         case ($urandom_range(0, 9))
            0:       strip_d[STRIP_W-1:0] = '0;
            1:       strip_d[STRIP_W-1:0] = 11'd1;
            2:       strip_d[STRIP_W-1:0] = STRIP_W'(MAX_LEDS_DEF);
            3:       strip_d[STRIP_W-1:0] = STRIP_W'($urandom_range(MAX_LEDS_DEF + 1, 2047));
            4, 5:    strip_d[STRIP_W-1:0] = STRIP_W'($urandom_range(1, 16));
            default: strip_d[STRIP_W-1:0] = STRIP_W'($urandom_range(1, MAX_LEDS_DEF));
         endcase
         step_d = CSR_DATA_W'($urandom);
         case ($urandom_range(0, 7))
            0:       step_d[STEP_W-1:0] = STEP_W'(-360);
            1:       step_d[STEP_W-1:0] = STEP_W'(360);
            2:       ; // raw field, includes steps beyond a full turn
            default: step_d[STEP_W-1:0] = STEP_W'(int'($urandom_range(0, 720)) - 360);
         endcase
         case ($urandom_range(0, 7))
            0:       wave_d = '0;
            1:       wave_d = 16'hFFFF;
            2:       wave_d = CSR_DATA_W'($urandom_range(1, 16'h0400));
            default: wave_d = CSR_DATA_W'($urandom);
         endcase
         apply_settings(strip_d, step_d, wave_d, $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 4) != 0) begin
            // frames: start flag on the first LED, then consecutive indexes
            repeat ($urandom_range(1, 3)) begin
               span = $urandom_range(1, 24);
               base = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 1023);
               for (int k = 0; k < span; k++) begin
                  w.frame_start = (k == 0);
                  w.led_index   = INDEX_W'(base + k);
                  send_word(w);
                  sent++;
               end
            end
         end else begin
            repeat ($urandom_range(1, 20)) begin
               w.frame_start = 1'($urandom_range(0, 1));
               w.led_index   = INDEX_W'($urandom);
               send_word(w);
               sent++;
            end
         end
      end
      settle_idle();
   endtask

   // Random traffic under three idle mixes: slow receiver, slow sender, none
   task automatic test_random_traffic();
      req_idle_pct = 24;
      rsp_idle_pct = 46;
      run_random_frames(517);
      req_idle_pct = 46;
      rsp_idle_pct = 24;
      run_random_frames(517);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random_frames(516);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_sweep_extremes();
      test_strip_limits();
      test_phase_wrap();
      test_random_traffic();
      settle_idle();
      if (error_count == 0) begin
         $display("rainbow_led_color_generator_top_tb passed");
      end else begin
         $display("rainbow_led_color_generator_top_tb failed");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run
   initial begin
      #20000000;
      $display("rainbow_led_color_generator_top_tb failed");
      $finish;
   end

endmodule
